// ----- src/licc_pkg.sv -----
// Shared types, constants and helpers for the label interning co-occurrence counter.
// Depends on nothing; every other file in src imports it.
`default_nettype none

package licc_pkg;

    localparam int KEY_CHARS  = 8;
    localparam int MAX_LABELS = 64;
    localparam int COUNT_BITS = 32;

    localparam int IDX_W   = $clog2(MAX_LABELS);
    localparam int USED_W  = $clog2(MAX_LABELS + 1);
    localparam int CELL_AW = 2 * IDX_W;

    // request kinds
    localparam logic [1:0] REQ_RECORD = 2'd0;
    localparam logic [1:0] REQ_CELL   = 2'd1;
    localparam logic [1:0] REQ_LABEL  = 2'd2;

    // result status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] past_key;
        logic [63:0] future_key;
        logic [5:0]  row_index;
        logic [5:0]  col_index;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  past_index;
        logic [5:0]  future_index;
        logic [31:0] cell_count;
        logic [63:0] label_value;
        logic [6:0]  label_count;
        logic [31:0] total_pairs;
    } t_res;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_INS_P,
        ST_INS_F,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_CELL,
        ST_CELL_FIN,
        ST_LBL,
        ST_LBL_FIN,
        ST_NOP
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_SCAN,
        OP_INS_P,
        OP_INS_F,
        OP_CNT_RD,
        OP_CELL_RD,
        OP_LBL_RD,
        OP_FIN_REC,
        OP_FIN_FULL,
        OP_FIN_BAD,
        OP_FIN_CELL,
        OP_FIN_LBL,
        OP_FIN_NOP
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic scan_done;
        logic full;
        logic cell_ok;
        logic lbl_ok;
    } t_sts;

    function automatic logic op_is_fin(input t_op op);
        return (op == OP_FIN_REC) || (op == OP_FIN_FULL) || (op == OP_FIN_BAD) ||
               (op == OP_FIN_CELL) || (op == OP_FIN_LBL) || (op == OP_FIN_NOP);
    endfunction

    // clear every byte from the first zero byte on
    function automatic logic [63:0] norm_key(input logic [63:0] k);
        logic [63:0] r;
        logic        stop;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < KEY_CHARS; i++) begin
            if (k[8*i +: 8] == 8'h00) begin
                stop = 1'b1;
            end
            if (!stop) begin
                r[8*i +: 8] = k[8*i +: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ----- src/licc_ctrl.sv -----
// Control FSM: sequences clearing, scan, insert, count update and cell and label reads.
// Depends on licc_pkg; drives licc_dpath through t_cmd and watches its t_sts.
`default_nettype none

module licc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic [1:0]    i_req_type,
    input  wire licc_pkg::t_sts i_sts,
    output licc_pkg::t_cmd     o_cmd,
    output logic               busy
);
    import licc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    unique case (i_req_type)
                        REQ_RECORD: n_state = ST_SCAN;
                        REQ_CELL:   n_state = ST_CELL;
                        REQ_LABEL:  n_state = ST_LBL;
                        default:    n_state = ST_NOP;
                    endcase
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_state = i_sts.full ? ST_IDLE : ST_INS_P;
            end
            ST_INS_P:    n_state = ST_INS_F;
            ST_INS_F:    n_state = ST_CNT_RD;
            ST_CNT_RD:   n_state = ST_CNT_WR;
            ST_CNT_WR:   n_state = ST_IDLE;
            ST_CELL: begin
                n_state = i_sts.cell_ok ? ST_CELL_FIN : ST_IDLE;
            end
            ST_CELL_FIN: n_state = ST_IDLE;
            ST_LBL: begin
                n_state = i_sts.lbl_ok ? ST_LBL_FIN : ST_IDLE;
            end
            ST_LBL_FIN:  n_state = ST_IDLE;
            ST_NOP:      n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op = OP_NONE;
        unique case (r_state)
            ST_CLEAR:    o_cmd.op = OP_CLEAR;
            ST_IDLE:     o_cmd.op = start ? OP_LOAD : OP_NONE;
            ST_SCAN:     o_cmd.op = OP_SCAN;
            ST_DECIDE:   o_cmd.op = i_sts.full ? OP_FIN_FULL : OP_NONE;
            ST_INS_P:    o_cmd.op = OP_INS_P;
            ST_INS_F:    o_cmd.op = OP_INS_F;
            ST_CNT_RD:   o_cmd.op = OP_CNT_RD;
            ST_CNT_WR:   o_cmd.op = OP_FIN_REC;
            ST_CELL:     o_cmd.op = i_sts.cell_ok ? OP_CELL_RD : OP_FIN_BAD;
            ST_CELL_FIN: o_cmd.op = OP_FIN_CELL;
            ST_LBL:      o_cmd.op = i_sts.lbl_ok ? OP_LBL_RD : OP_FIN_BAD;
            ST_LBL_FIN:  o_cmd.op = OP_FIN_LBL;
            ST_NOP:      o_cmd.op = OP_FIN_NOP;
            default:     o_cmd.op = OP_NONE;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

    // a finished request always hands control back to idle
    a_fin_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op_is_fin(o_cmd.op) |=> (r_state == ST_IDLE))
        else $error("request finished without returning to idle");

    // a scan is only ever entered from idle
    a_scan_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ($past(r_state) == ST_IDLE || $past(r_state) == ST_SCAN))
        else $error("scan entered from an unexpected state");

    // an accepted request leaves idle at once
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

endmodule

`default_nettype wire

// ----- src/licc_dpath.sv -----
// Datapath: label memory, pair count memory, key compare, counters and result register.
// Depends on licc_pkg; commanded by licc_ctrl through t_cmd, reports through t_sts.
`default_nettype none

module licc_dpath (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire licc_pkg::t_req i_req,
    input  wire licc_pkg::t_cmd i_cmd,
    output licc_pkg::t_sts      o_sts,
    output licc_pkg::t_res      o_res,
    output logic                o_valid
);
    import licc_pkg::*;

    logic [63:0]           m_lbl [MAX_LABELS];
    logic [COUNT_BITS-1:0] m_cnt [MAX_LABELS*MAX_LABELS];

    t_req                  r_in;
    logic [63:0]           r_pk;
    logic [63:0]           r_fk;
    logic [USED_W-1:0]     r_used;
    logic [COUNT_BITS-1:0] r_total;
    logic [CELL_AW-1:0]    r_clr;
    logic [USED_W-1:0]     r_addr;
    logic                  r_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_pfound;
    logic                  r_ffound;
    logic [IDX_W-1:0]      r_pp;
    logic [IDX_W-1:0]      r_fp;
    logic [63:0]           r_lbl_rd;
    logic [COUNT_BITS-1:0] r_cnt_rd;
    t_res                  r_res;
    logic                  r_res_vld;

    logic                  w_keq;
    logic [1:0]            w_need;
    logic [USED_W:0]       w_sum;
    logic                  w_scan_hit;
    logic [IDX_W-1:0]      w_row;
    logic [IDX_W-1:0]      w_col;
    logic [IDX_W-1:0]      w_lbl_raddr;
    logic                  w_lbl_we;
    logic [63:0]           w_lbl_wdata;
    logic [CELL_AW-1:0]    w_cnt_raddr;
    logic                  w_cnt_we;
    logic [CELL_AW-1:0]    w_cnt_waddr;
    logic [COUNT_BITS-1:0] w_cnt_wdata;
    logic                  w_fin;
    t_res                  w_res;

    assign w_row      = IDX_W'(r_in.row_index);
    assign w_col      = IDX_W'(r_in.col_index);
    assign w_keq      = (r_pk == r_fk);
    assign w_need     = {1'b0, !r_pfound} + {1'b0, (!r_ffound && !(!r_pfound && w_keq))};
    assign w_sum      = {1'b0, r_used} + (USED_W+1)'(w_need);
    assign w_scan_hit = (r_addr < r_used);
    assign w_fin      = op_is_fin(i_cmd.op);

    assign o_sts.clr_last  = &r_clr;
    assign o_sts.scan_done = (r_addr == r_used) && !r_cmp_vld;
    assign o_sts.full      = (w_sum > (USED_W+1)'(MAX_LABELS));
    assign o_sts.cell_ok   = (USED_W'(r_in.row_index) < r_used) &&
                             (USED_W'(r_in.col_index) < r_used);
    assign o_sts.lbl_ok    = (USED_W'(r_in.row_index) < r_used);

    // memory port steering
    always_comb begin
        w_lbl_raddr = (i_cmd.op == OP_LBL_RD) ? w_row : r_addr[IDX_W-1:0];
        w_lbl_we    = 1'b0;
        w_lbl_wdata = r_pk;
        if (i_cmd.op == OP_INS_P && !r_pfound) begin
            w_lbl_we = 1'b1;
        end
        if (i_cmd.op == OP_INS_F && !r_ffound && !w_keq) begin
            w_lbl_we    = 1'b1;
            w_lbl_wdata = r_fk;
        end
        w_cnt_raddr = (i_cmd.op == OP_CELL_RD) ? {w_row, w_col} : {r_pp, r_fp};
        w_cnt_we    = 1'b0;
        w_cnt_waddr = {r_pp, r_fp};
        w_cnt_wdata = sat_inc(r_cnt_rd);
        if (i_cmd.op == OP_CLEAR) begin
            w_cnt_we    = 1'b1;
            w_cnt_waddr = r_clr;
            w_cnt_wdata = '0;
        end else if (i_cmd.op == OP_FIN_REC) begin
            w_cnt_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lbl_we) begin
            m_lbl[r_used[IDX_W-1:0]] <= w_lbl_wdata;
        end
        r_lbl_rd <= m_lbl[w_lbl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            m_cnt[w_cnt_waddr] <= w_cnt_wdata;
        end
        r_cnt_rd <= m_cnt[w_cnt_raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_total   <= '0;
            r_clr     <= '0;
            r_addr    <= '0;
            r_cmp_vld <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= w_fin;
            unique case (i_cmd.op)
                OP_CLEAR: r_clr <= r_clr + 1'b1;
                OP_LOAD: begin
                    r_addr    <= '0;
                    r_cmp_vld <= 1'b0;
                end
                OP_SCAN: begin
                    r_cmp_vld <= w_scan_hit;
                    if (w_scan_hit) r_addr <= r_addr + 1'b1;
                end
                OP_INS_P: begin
                    if (!r_pfound) r_used <= r_used + 1'b1;
                end
                OP_INS_F: begin
                    if (!r_ffound && !w_keq) r_used <= r_used + 1'b1;
                end
                OP_FIN_REC: r_total <= sat_inc(r_total);
                default: ;
            endcase
        end
    end

    // payload and search results
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_in     <= i_req;
            r_pk     <= norm_key(i_req.past_key);
            r_fk     <= norm_key(i_req.future_key);
            r_pfound <= 1'b0;
            r_ffound <= 1'b0;
        end else if (r_cmp_vld) begin
            // stored labels are unique, so at most one entry hits each key
            if (r_lbl_rd == r_pk) begin
                r_pfound <= 1'b1;
                r_pp     <= r_cmp_idx;
            end
            if (r_lbl_rd == r_fk) begin
                r_ffound <= 1'b1;
                r_fp     <= r_cmp_idx;
            end
        end
        if (i_cmd.op == OP_SCAN) begin
            r_cmp_idx <= r_addr[IDX_W-1:0];
        end
        if (i_cmd.op == OP_INS_P && !r_pfound) begin
            r_pp <= r_used[IDX_W-1:0];
        end
        if (i_cmd.op == OP_INS_F && !r_ffound) begin
            // a new future key equal to the new past key shares its label
            r_fp <= w_keq ? r_pp : r_used[IDX_W-1:0];
        end
        if (w_fin) begin
            r_res <= w_res;
        end
    end

    always_comb begin
        w_res              = '0;
        w_res.status       = STS_OK;
        w_res.label_count  = 7'(r_used);
        w_res.total_pairs  = 32'(r_total);
        unique case (i_cmd.op)
            OP_FIN_REC: begin
                w_res.past_index   = 6'(r_pp);
                w_res.future_index = 6'(r_fp);
                w_res.cell_count   = 32'(sat_inc(r_cnt_rd));
                w_res.total_pairs  = 32'(sat_inc(r_total));
            end
            OP_FIN_FULL: w_res.status      = STS_FULL;
            OP_FIN_BAD:  w_res.status      = STS_RANGE;
            OP_FIN_CELL: w_res.cell_count  = 32'(r_cnt_rd);
            OP_FIN_LBL:  w_res.label_value = r_lbl_rd;
            default: ;
        endcase
    end

    assign o_res   = r_res;
    assign o_valid = r_res_vld;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(MAX_LABELS))
        else $error("label count beyond dictionary size");

    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_total >= $past(r_total)))
        else $error("pair total went backwards");

    a_rec_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_FIN_REC) |=> (o_res.cell_count != 32'd0 && o_res.total_pairs != 32'd0))
        else $error("recorded pair left a zero count");

endmodule

`default_nettype wire

// ----- src/label_interning_cooccurrence_counter_unit.sv -----
// Top level of the label interning co-occurrence counter.
// Depends on licc_pkg, licc_ctrl and licc_dpath.
//
// Usage:
//   Present a request on i_req and raise start; it is taken at a rising edge where start
//   is high and busy is low. Request kinds: record a past/future key pair, read one
//   matrix cell, read one stored label. Each request gives exactly one result on o_res,
//   shown for one cycle with o_valid high; the receiver cannot hold it off.
//   What each request kind does:
//     record pair : scan of the label memory, one entry compared per cycle, both keys
//                   at once, then insert and a read-modify-write of the count
//     full dict   : the scan, then a STS_FULL result with nothing inserted
//     cell read   : one count memory read; label read: one label memory read
//     bad index   : STS_RANGE result with no read; unused kind: STS_OK, no payload
//   A new request may be taken in the cycle the previous result is shown.
//   After reset the block sweeps all MAX_LABELS * MAX_LABELS (4096) cells of the pair
//   count memory to zero, one cell per cycle, holding busy high throughout. The label
//   memory is not cleared; only filled entries are ever compared or returned.
`default_nettype none

module label_interning_cooccurrence_counter_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire licc_pkg::t_req i_req,
    output logic                busy,
    output logic                o_valid,
    output licc_pkg::t_res      o_res
);
    import licc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    licc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req.req_type),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .busy       (busy)
    );

    licc_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_res   (o_res),
        .o_valid (o_valid)
    );

endmodule

`default_nettype wire
